FILE: src/dms_pkg.sv
// shared types and constants of the drive mode supervisor
package dms_pkg;

   // drive modes held by the supervisor
   typedef enum logic [1:0] {
      DRIVE_INIT   = 2'd0,
      DRIVE_CRUISE = 2'd1,
      DRIVE_AVOID  = 2'd2,
      DRIVE_SAFE   = 2'd3
   } drive_mode_type;

   // corridor status codes
   localparam logic [1:0] STATUS_FREE    = 2'd0;
   localparam logic [1:0] STATUS_WARNING = 2'd1;
   localparam logic [1:0] STATUS_BLOCKED = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // request kinds; the fourth code means nothing and changes nothing
   localparam logic [1:0] KIND_ACTIVATE = 2'd0;
   localparam logic [1:0] KIND_STATUS   = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;

   // widths
   localparam int TIME_W     = 32;
   localparam int RUN_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [TIME_W-1:0]     time_ms_type;
   typedef logic [RUN_W-1:0]      run_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // configuration register indexes
   localparam csr_idx_type CSR_STALE_TIMEOUT     = 3'd0;
   localparam csr_idx_type CSR_BOOTSTRAP_TIMEOUT = 3'd1;
   localparam csr_idx_type CSR_FREE_DEBOUNCE     = 3'd2;
   localparam csr_idx_type CSR_WARNING_TO_AVOID  = 3'd3;

   // configuration reset values
   localparam time_ms_type STALE_TIMEOUT_RST     = 32'd500;
   localparam time_ms_type BOOTSTRAP_TIMEOUT_RST = 32'd5000;
   localparam run_type     FREE_DEBOUNCE_RST     = 8'd3;
   localparam run_type     FREE_RUN_MAX          = 8'd255;

endpackage

FILE: src/dms_if.sv
// request, response and configuration channel interfaces
interface dms_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [1:0]          status;
   dms_pkg::time_ms_type time_ms;

   modport source (output valid, output mode, output status, output time_ms, input ready);
   modport sink   (input valid, input mode, input status, input time_ms, output ready);
endinterface

interface dms_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] drive_mode;
   logic       stale;

   modport source (output valid, output drive_mode, output stale, input ready);
   modport sink   (input valid, input drive_mode, input stale, output ready);
endinterface

interface dms_csr_if;
   logic                  valid;
   logic                  ready;
   dms_pkg::csr_idx_type  index;
   dms_pkg::csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/drive_mode_supervisor_core.sv
// drive mode supervisor: input register, mode update logic and response register
// The supervisor takes one request (activate, status report or tick) per clock cycle and
// returns exactly one response per request, when the response side is ready. Each request
// is held in an input register; once the response register can take it, the mode logic
// (two 32-bit age subtractions with compares, a saturating free-run counter and the mode
// transition) updates the state and loads the response register, so the state written by
// one request is seen by the very next one. Either side may stall: the input register and
// the response register keep a full request flowing without loss. Configuration writes on
// the csr channel are always accepted and must only be made while no request is in
// flight; after reset the stale timeout is 500 ms, the bootstrap timeout 5000 ms,
// the free debounce 3 and warning-to-avoidance off. Writes to unused indexes are ignored.
module drive_mode_supervisor_core (
   input logic        clock,
   input logic        reset,
   dms_req_if.sink    req_chan,
   dms_rsp_if.source  rsp_chan,
   dms_csr_if.sink    csr_chan
);
   import dms_pkg::*;

   // configuration registers
   time_ms_type stale_timeout_ff, stale_timeout_in;
   time_ms_type boot_timeout_ff,  boot_timeout_in;
   run_type     free_debounce_ff, free_debounce_in;
   logic        warn_avoid_ff,    warn_avoid_in;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff,  s1_kind_in;
   logic [1:0]  s1_status_ff, s1_status_in;
   time_ms_type s1_time_ff,  s1_time_in;

   // supervisor state
   drive_mode_type mode_ff, mode_in;
   logic [1:0]     last_status_ff, last_status_in;
   logic           status_seen_ff, status_seen_in;
   time_ms_type    status_time_ff, status_time_in;
   logic           activated_ff,   activated_in;
   time_ms_type    activate_time_ff, activate_time_in;
   run_type        free_run_ff,    free_run_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_mode_ff,  rsp_mode_in;
   logic       rsp_stale_ff, rsp_stale_in;

   logic        advance;
   logic        req_take;
   time_ms_type status_age;
   time_ms_type activate_age;
   logic        stale_hit;
   logic        boot_expired;
   logic        free_ok;
   logic        stale_flag;

   // handshakes
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.drive_mode = rsp_mode_ff;
   assign rsp_chan.stale      = rsp_stale_ff;

   // configuration writes
   always_comb begin
      stale_timeout_in = stale_timeout_ff;
      boot_timeout_in  = boot_timeout_ff;
      free_debounce_in = free_debounce_ff;
      warn_avoid_in    = warn_avoid_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_STALE_TIMEOUT:     stale_timeout_in = csr_chan.data;
            CSR_BOOTSTRAP_TIMEOUT: boot_timeout_in  = csr_chan.data;
            CSR_FREE_DEBOUNCE:     free_debounce_in = csr_chan.data[RUN_W-1:0];
            CSR_WARNING_TO_AVOID:  warn_avoid_in    = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // input register loading
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_kind_in   = s1_kind_ff;
      s1_status_in = s1_status_ff;
      s1_time_in   = s1_time_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_kind_in   = req_chan.mode;
         s1_status_in = req_chan.status;
         s1_time_in   = req_chan.time_ms;
      end
   end

   // timeout checks, ages modulo 2^32
   assign status_age   = s1_time_ff - status_time_ff;
   assign activate_age = s1_time_ff - activate_time_ff;
   assign stale_hit    = status_seen_ff && (status_age > stale_timeout_ff);
   assign boot_expired = activated_ff && (activate_age > boot_timeout_ff);
   assign free_ok      = (last_status_ff == STATUS_FREE) && (free_run_ff >= free_debounce_ff);

   // mode transitions and state update
   always_comb begin
      mode_in          = mode_ff;
      last_status_in   = last_status_ff;
      status_seen_in   = status_seen_ff;
      status_time_in   = status_time_ff;
      activated_in     = activated_ff;
      activate_time_in = activate_time_ff;
      free_run_in      = free_run_ff;
      stale_flag       = 1'b0;
      if (advance) begin
         case (s1_kind_ff)
            KIND_ACTIVATE: begin
               mode_in          = DRIVE_INIT;
               activate_time_in = s1_time_ff;
               activated_in     = 1'b1;
               status_seen_in   = 1'b0;
               last_status_in   = STATUS_UNKNOWN;
               free_run_in      = '0;
            end
            KIND_STATUS: begin
               last_status_in = s1_status_ff;
               status_time_in = s1_time_ff;
               status_seen_in = 1'b1;
               if (s1_status_ff == STATUS_FREE) begin
                  if (free_run_ff != FREE_RUN_MAX) begin
                     free_run_in = free_run_ff + 1'b1;
                  end
               end else begin
                  free_run_in = '0;
               end
            end
            KIND_TICK: begin
               if (stale_hit) begin
                  stale_flag = 1'b1;
                  if (mode_ff != DRIVE_SAFE) begin
                     mode_in = DRIVE_AVOID;
                  end
               end else begin
                  case (mode_ff)
                     DRIVE_INIT: begin
                        if (status_seen_ff) begin
                           if (last_status_ff == STATUS_BLOCKED) begin
                              mode_in = DRIVE_AVOID;
                           end else if (free_ok) begin
                              mode_in = DRIVE_CRUISE;
                           end
                        end else if (boot_expired) begin
                           mode_in = DRIVE_SAFE;
                        end
                     end
                     DRIVE_CRUISE: begin
                        if (last_status_ff == STATUS_BLOCKED ||
                            (last_status_ff == STATUS_WARNING && warn_avoid_ff)) begin
                           mode_in = DRIVE_AVOID;
                        end
                     end
                     DRIVE_AVOID: begin
                        if (free_ok) begin
                           mode_in = DRIVE_CRUISE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // response register loading
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_stale_in = rsp_stale_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_mode_in  = mode_in;
         rsp_stale_in = stale_flag;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stale_timeout_ff <= STALE_TIMEOUT_RST;
         boot_timeout_ff  <= BOOTSTRAP_TIMEOUT_RST;
         free_debounce_ff <= FREE_DEBOUNCE_RST;
         warn_avoid_ff    <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mode_ff          <= DRIVE_INIT;
         last_status_ff   <= STATUS_UNKNOWN;
         status_seen_ff   <= 1'b0;
         status_time_ff   <= '0;
         activated_ff     <= 1'b0;
         activate_time_ff <= '0;
         free_run_ff      <= '0;
      end else begin
         stale_timeout_ff <= stale_timeout_in;
         boot_timeout_ff  <= boot_timeout_in;
         free_debounce_ff <= free_debounce_in;
         warn_avoid_ff    <= warn_avoid_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         mode_ff          <= mode_in;
         last_status_ff   <= last_status_in;
         status_seen_ff   <= status_seen_in;
         status_time_ff   <= status_time_in;
         activated_ff     <= activated_in;
         activate_time_ff <= activate_time_in;
         free_run_ff      <= free_run_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_status_ff <= s1_status_in;
      s1_time_ff   <= s1_time_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_stale_ff <= rsp_stale_in;
   end

`ifndef SYNTHESIS
   // no response straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // safe stop is left only by an activate request
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == DRIVE_SAFE && !(advance && s1_kind_ff == KIND_ACTIVATE))
      |=> mode_ff == DRIVE_SAFE)
      else $error("safe stop left without activate");

   // stale flag only from a tick
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_kind_ff != KIND_TICK) |=> !rsp_stale_ff)
      else $error("stale flag on a non-tick request");

   // activate clears the status history
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_kind_ff == KIND_ACTIVATE)
      |=> (free_run_ff == '0 && !status_seen_ff && mode_ff == DRIVE_INIT))
      else $error("activate did not restart the supervisor");

   // a waiting response is not overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !advance)
      else $error("response overwritten while stalled");
`endif

endmodule

FILE: verif/drive_mode_supervisor_core_tb.sv
// self-checking testbench of the drive mode supervisor core
module drive_mode_supervisor_core_tb;
   import dms_pkg::*;

   // request kind with no meaning, and a register index that does not exist
   localparam logic [1:0]  KIND_NONE      = 2'd3;
   localparam csr_idx_type CSR_UNUSED_IDX = 3'd7;

   typedef struct packed {
      drive_mode_type mode;
      logic           stale;
   } mode_result_type;

   // tracks the supervisor state and holds the responses still owed
   class mode_scoreboard;
      time_ms_type     stale_limit;
      time_ms_type     boot_limit;
      run_type         debounce;
      logic            warn_avoid;
      drive_mode_type  mode_q;
      logic [1:0]      last_st;
      logic            seen;
      time_ms_type     st_time;
      logic            active;
      time_ms_type     act_time;
      run_type         free_run;
      mode_result_type owed_modes[$];
      int              errors;

      function new();
         stale_limit = STALE_TIMEOUT_RST;
         boot_limit  = BOOTSTRAP_TIMEOUT_RST;
         debounce    = FREE_DEBOUNCE_RST;
         warn_avoid  = 1'b0;
         mode_q      = DRIVE_INIT;
         last_st     = STATUS_UNKNOWN;
         seen        = 1'b0;
         st_time     = '0;
         active      = 1'b0;
         act_time    = '0;
         free_run    = '0;
         errors      = 0;
      endfunction

      function void set_reg(csr_idx_type idx, csr_data_type val);
         case (idx)
            CSR_STALE_TIMEOUT:     stale_limit = val;
            CSR_BOOTSTRAP_TIMEOUT: boot_limit  = val;
            CSR_FREE_DEBOUNCE:     debounce    = val[RUN_W-1:0];
            CSR_WARNING_TO_AVOID:  warn_avoid  = val[0];
            default: ;
         endcase
      endfunction

      // apply one accepted request and queue the response it owes
      function void note_request(logic [1:0] kind, logic [1:0] st, time_ms_type now);
         mode_result_type res;
         time_ms_type     st_age;
         time_ms_type     act_age;
         logic            free_ok;
         res.stale = 1'b0;
         case (kind)
            KIND_ACTIVATE: begin
               mode_q   = DRIVE_INIT;
               act_time = now;
               active   = 1'b1;
               seen     = 1'b0;
               last_st  = STATUS_UNKNOWN;
               free_run = '0;
            end
            KIND_STATUS: begin
               last_st = st;
               st_time = now;
               seen    = 1'b1;
               if (st == STATUS_FREE) begin
                  if (free_run != FREE_RUN_MAX) free_run = free_run + 1'b1;
               end else begin
                  free_run = '0;
               end
            end
            KIND_TICK: begin
               st_age  = now - st_time;
               act_age = now - act_time;
               free_ok = (last_st == STATUS_FREE) && (free_run >= debounce);
               if (seen && st_age > stale_limit) begin
                  // stale status forces avoidance unless already stopped
                  if (mode_q != DRIVE_SAFE) mode_q = DRIVE_AVOID;
                  res.stale = 1'b1;
               end else begin
                  case (mode_q)
                     DRIVE_INIT: begin
                        if (seen) begin
                           if (last_st == STATUS_BLOCKED) mode_q = DRIVE_AVOID;
                           else if (free_ok) mode_q = DRIVE_CRUISE;
                        end else if (active && act_age > boot_limit) begin
                           mode_q = DRIVE_SAFE;
                        end
                     end
                     DRIVE_CRUISE: begin
                        if (last_st == STATUS_BLOCKED ||
                            (last_st == STATUS_WARNING && warn_avoid))
                           mode_q = DRIVE_AVOID;
                     end
                     DRIVE_AVOID: begin
                        if (free_ok) mode_q = DRIVE_CRUISE;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
         res.mode = mode_q;
         owed_modes.push_back(res);
      endfunction

      // compare one response with the oldest owed one
      function void check_response(logic [1:0] got_mode, logic got_stale);
         mode_result_type exp;
         if (owed_modes.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual mode %0d stale %0d",
                     $time, got_mode, got_stale);
         end else begin
            exp = owed_modes.pop_front();
            if (got_mode !== exp.mode) begin
               errors++;
               $display("%0t: drive_mode mismatch, expected %0d actual %0d",
                        $time, exp.mode, got_mode);
            end
            if (got_stale !== exp.stale) begin
               errors++;
               $display("%0t: stale mismatch, expected %0d actual %0d",
                        $time, exp.stale, got_stale);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic idle_on = 1'b1;
   int   stall_left = 0;
   time_ms_type now_ms;

   mode_scoreboard sb = new();

   dms_req_if req_chan();
   dms_rsp_if rsp_chan();
   dms_csr_if csr_chan();

   drive_mode_supervisor_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // response side: check accepted responses, stall in random bursts while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.drive_mode, rsp_chan.stale);
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // one request; valid stays high afterwards for a following request
   task automatic send_request(logic [1:0] kind, logic [1:0] st, time_ms_type t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= kind;
      req_chan.status  <= st;
      req_chan.time_ms <= t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(kind, st, t);
   endtask

   // one register write; valid stays high for a following write
   task automatic write_reg(csr_idx_type idx, csr_data_type val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // stop sending and let every owed response come back
   task automatic drain;
      req_chan.valid <= 1'b0;
      while (sb.owed_modes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(time_ms_type stale_v, time_ms_type boot_v, run_type deb_v,
                               logic warn_v, logic poke_unused);
      write_reg(CSR_STALE_TIMEOUT, stale_v);
      write_reg(CSR_BOOTSTRAP_TIMEOUT, boot_v);
      write_reg(CSR_FREE_DEBOUNCE, {24'($urandom), deb_v});
      write_reg(CSR_WARNING_TO_AVOID, {31'($urandom), warn_v});
      if (poke_unused) write_reg(CSR_UNUSED_IDX, $urandom);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic time_ms_type span_of(time_ms_type x);
      return (x > 32'h7FFF_FFFE) ? '1 : x * 2 + 2;
   endfunction

   // random request with a timestamp that mostly moves forward
   task automatic random_request;
      int         pick;
      logic [1:0] kind;
      logic [1:0] st;
      pick = $urandom_range(0, 99);
      if (pick < 45)      now_ms = now_ms + $urandom_range(0, 4);
      else if (pick < 80) now_ms = now_ms + $urandom_range(0, span_of(sb.stale_limit));
      else if (pick < 92) now_ms = now_ms + $urandom_range(0, span_of(sb.boot_limit));
      else if (pick < 98) now_ms = now_ms + $urandom;
      else                now_ms = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 8)       kind = KIND_ACTIVATE;
      else if (pick < 50) kind = KIND_STATUS;
      else if (pick < 95) kind = KIND_TICK;
      else                kind = KIND_NONE;
      st = ($urandom_range(0, 99) < 55) ? STATUS_FREE : 2'($urandom_range(1, 3));
      if (kind != KIND_STATUS && $urandom_range(0, 1)) st = 2'($urandom);
      send_request(kind, st, now_ms);
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.mode    <= KIND_ACTIVATE;
      req_chan.status  <= STATUS_FREE;
      req_chan.time_ms <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= CSR_STALE_TIMEOUT;
      csr_chan.data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed at reset settings: bootstrap, stale edges and init->safe->init->avoid->cruise->avoid
      send_request(KIND_TICK, STATUS_BLOCKED, 32'd0);
      send_request(KIND_TICK, STATUS_FREE, 32'hFFFF_FFFF);
      send_request(KIND_NONE, STATUS_BLOCKED, 32'd12);
      send_request(KIND_ACTIVATE, STATUS_WARNING, 32'd1000);
      send_request(KIND_TICK, STATUS_FREE, 32'd6000);
      send_request(KIND_TICK, STATUS_FREE, 32'd6001);
      send_request(KIND_STATUS, STATUS_FREE, 32'd6002);
      send_request(KIND_TICK, STATUS_FREE, 32'd6502);
      send_request(KIND_TICK, STATUS_FREE, 32'd6503);
      send_request(KIND_ACTIVATE, STATUS_FREE, 32'd7000);
      send_request(KIND_STATUS, STATUS_BLOCKED, 32'd7000);
      send_request(KIND_TICK, STATUS_FREE, 32'd7001);
      send_request(KIND_STATUS, STATUS_FREE, 32'd7010);
      send_request(KIND_STATUS, STATUS_FREE, 32'd7020);
      send_request(KIND_TICK, STATUS_FREE, 32'd7025);
      send_request(KIND_STATUS, STATUS_FREE, 32'd7030);
      send_request(KIND_TICK, STATUS_FREE, 32'd7040);
      send_request(KIND_STATUS, STATUS_WARNING, 32'd7050);
      send_request(KIND_TICK, STATUS_FREE, 32'd7060);
      send_request(KIND_STATUS, STATUS_UNKNOWN, 32'd7070);
      send_request(KIND_TICK, STATUS_FREE, 32'd7071);
      send_request(KIND_STATUS, STATUS_BLOCKED, 32'd7080);
      send_request(KIND_TICK, STATUS_FREE, 32'd7090);
      send_request(KIND_TICK, STATUS_FREE, 32'd7700);
      send_request(KIND_NONE, STATUS_UNKNOWN, 32'hFFFF_FFFF);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         // settings: lowest, highest, then moderate random ones
         case (phase)
            0: program_regs('0, '0, '0, 1'b1, 1'b1);
            1: program_regs('1, '1, FREE_RUN_MAX, 1'b0, 1'b0);
            default: program_regs($urandom_range(20, 400), $urandom_range(50, 2000),
                                  run_type'($urandom_range(0, 6)), 1'($urandom), 1'b1);
         endcase
         now_ms = (phase == 4) ? 32'hFFFF_F000 : 32'($urandom_range(0, 100000));
         if (phase == 5) idle_on = 1'b0;

         // full debounce: just short of it, reach it, then run past saturation
         if (phase == 1) begin
            send_request(KIND_ACTIVATE, STATUS_FREE, now_ms);
            repeat (254) send_request(KIND_STATUS, STATUS_FREE, now_ms);
            send_request(KIND_TICK, STATUS_FREE, now_ms);
            repeat (3) send_request(KIND_STATUS, STATUS_FREE, now_ms);
            send_request(KIND_TICK, STATUS_FREE, now_ms);
            send_request(KIND_STATUS, STATUS_WARNING, now_ms);
            send_request(KIND_TICK, STATUS_FREE, now_ms);
         end

         for (int n = 0; n < 55; n++) begin
            if (phase == 3 && n == 50) drain();
            random_request();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.owed_modes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
